/* hdl/sscp_pkg.sv */
// ============================================================================
// sscp_pkg
// Shared widths, payload types and control structs for the segment
// closest-points pipeline.
// ============================================================================
`default_nettype none

package sscp_pkg;

    // fixed widths of the register and the result word
    localparam int THR_W      = 40;
    localparam int DIST_W     = 34;
    localparam int PARAM_W    = 17;
    localparam int POINT_W    = 24;
    localparam int POINT_FRAC = 8;

    // divider lanes
    localparam int LANE_A = 0;
    localparam int LANE_B = 1;

    typedef logic [THR_W-1:0]          thr_t;
    typedef logic [DIST_W-1:0]         dist_t;
    typedef logic [PARAM_W-1:0]        param_t;
    typedef logic signed [POINT_W-1:0] point_t;

    // per-lane divider control: result is known before the division
    typedef struct packed {
        logic fixed;
        logic one;
    } udiv_ctl_t;

endpackage

`default_nettype wire

/* hdl/sscp_if.sv */
// ============================================================================
// sscp_if
// Valid/ready channels for segment-pair words and closest-point words.
// ============================================================================
`default_nettype none

interface sscp_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_start_z;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] a_end_z;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_start_z;
    logic signed [COORD_BITS-1:0] b_end_x;
    logic signed [COORD_BITS-1:0] b_end_y;
    logic signed [COORD_BITS-1:0] b_end_z;

    modport source (
        output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
               b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
               b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
        output ready
    );
endinterface

interface sscp_out_if;
    logic             valid;
    logic             ready;
    sscp_pkg::dist_t  sq_dist;
    sscp_pkg::param_t u_a;
    sscp_pkg::param_t u_b;
    sscp_pkg::point_t closest_a_x;
    sscp_pkg::point_t closest_a_y;
    sscp_pkg::point_t closest_a_z;
    sscp_pkg::point_t closest_b_x;
    sscp_pkg::point_t closest_b_y;
    sscp_pkg::point_t closest_b_z;

    modport source (
        output valid, sq_dist, u_a, u_b, closest_a_x, closest_a_y, closest_a_z,
               closest_b_x, closest_b_y, closest_b_z,
        input  ready
    );
    modport sink (
        input  valid, sq_dist, u_a, u_b, closest_a_x, closest_a_y, closest_a_z,
               closest_b_x, closest_b_y, closest_b_z,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/segment_segment_closest_points.sv */
// Throughput: one word per cycle unless the output stalls; the divider spends
//   one pipeline stage per quotient bit, and a stalled output only holds the
//   stages that are full.
// Reset: clears the stage valid bits and the parallel threshold register.
// ============================================================================
// segment_segment_closest_points
// Closest points and squared distance of two 3D segments, fully pipelined.
// ============================================================================
`default_nettype none

module segment_segment_closest_points #(
    parameter int COORD_BITS      = 16,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sscp_in_if.sink               seg_in,
    sscp_out_if.source            seg_out,
    input  logic                  cfg_we,
    input  logic [sscp_pkg::THR_W-1:0] cfg_wdata
);

    localparam int DW  = COORD_BITS + 1;
    localparam int XW  = 2 * (2 * DW + 2) + 3;
    localparam int SBW = 6 * COORD_BITS + 9 * DW;
    localparam int NF  = 8;
    localparam int ND  = PARAM_FRAC_BITS + 1;
    localparam int NB  = 4;
    localparam int NS  = NF + ND + NB;

    // parallel threshold register
    sscp_pkg::thr_t thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // stage valid bits and per-stage advance, bubbles collapse
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || seg_out.ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = seg_in.valid;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign seg_in.ready  = en[0];
    assign seg_out.valid = vld_reg[NS-1];

    // input word as coordinate arrays
    logic signed [COORD_BITS-1:0] a_s [3];
    logic signed [COORD_BITS-1:0] a_e [3];
    logic signed [COORD_BITS-1:0] b_s [3];
    logic signed [COORD_BITS-1:0] b_e [3];

    assign a_s[0] = seg_in.a_start_x;
    assign a_s[1] = seg_in.a_start_y;
    assign a_s[2] = seg_in.a_start_z;
    assign a_e[0] = seg_in.a_end_x;
    assign a_e[1] = seg_in.a_end_y;
    assign a_e[2] = seg_in.a_end_z;
    assign b_s[0] = seg_in.b_start_x;
    assign b_s[1] = seg_in.b_start_y;
    assign b_s[2] = seg_in.b_start_z;
    assign b_e[0] = seg_in.b_end_x;
    assign b_e[1] = seg_in.b_end_y;
    assign b_e[2] = seg_in.b_end_z;

    logic signed [XW-1:0]  dnum [2];
    logic signed [XW-1:0]  dden [2];
    sscp_pkg::udiv_ctl_t   dctl [2];
    logic [SBW-1:0]        side_f;
    logic [SBW-1:0]        side_d;
    logic [PARAM_FRAC_BITS:0] u [2];
    sscp_pkg::point_t      pt_a [3];
    sscp_pkg::point_t      pt_b [3];

    sscp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk  (clk),
        .en   (en[NF-1:0]),
        .thr  (thr_reg),
        .a_s  (a_s),
        .a_e  (a_e),
        .b_s  (b_s),
        .b_e  (b_e),
        .num  (dnum),
        .den  (dden),
        .ctl  (dctl),
        .side (side_f)
    );

    sscp_div #(
        .COORD_BITS      (COORD_BITS),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .en       (en[NF+ND-1:NF]),
        .num      (dnum),
        .den      (dden),
        .ctl      (dctl),
        .side_in  (side_f),
        .u        (u),
        .side_out (side_d)
    );

    sscp_back #(
        .COORD_BITS      (COORD_BITS),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .en      (en[NS-1:NF+ND]),
        .u       (u),
        .side    (side_d),
        .sq_dist (seg_out.sq_dist),
        .u_a     (seg_out.u_a),
        .u_b     (seg_out.u_b),
        .pt_a    (pt_a),
        .pt_b    (pt_b)
    );

    assign seg_out.closest_a_x = pt_a[0];
    assign seg_out.closest_a_y = pt_a[1];
    assign seg_out.closest_a_z = pt_a[2];
    assign seg_out.closest_b_x = pt_b[0];
    assign seg_out.closest_b_y = pt_b[1];
    assign seg_out.closest_b_z = pt_b[2];

endmodule

`default_nettype wire

/* hdl/sscp_front.sv */
// ============================================================================
// sscp_front
// Eight stages: direction vectors, dot products, 2x2 determinant terms,
// parameter case split and divider operand setup.
// ============================================================================
`default_nettype none

module sscp_front #(
    parameter int COORD_BITS = 16,
    localparam int DW  = COORD_BITS + 1,
    localparam int PW  = 2 * DW,
    localparam int SW  = PW + 2,
    localparam int MW  = 2 * SW,
    localparam int XW  = MW + 3,
    localparam int SBW = 6 * COORD_BITS + 9 * DW
) (
    input  logic                         clk,
    input  logic [7:0]                   en,
    input  sscp_pkg::thr_t               thr,
    input  logic signed [COORD_BITS-1:0] a_s [3],
    input  logic signed [COORD_BITS-1:0] a_e [3],
    input  logic signed [COORD_BITS-1:0] b_s [3],
    input  logic signed [COORD_BITS-1:0] b_e [3],
    output logic signed [XW-1:0]         num [2],
    output logic signed [XW-1:0]         den [2],
    output sscp_pkg::udiv_ctl_t          ctl [2],
    output logic [SBW-1:0]               side
);

    localparam int OAS = 0;
    localparam int OBS = 3 * COORD_BITS;
    localparam int ODA = 6 * COORD_BITS;
    localparam int ODB = ODA + 3 * DW;
    localparam int OW  = ODB + 3 * DW;

    logic [SBW-1:0]       side_next;
    logic [SBW-1:0]       side_reg [8];
    logic signed [DW-1:0] g_da [3];
    logic signed [DW-1:0] g_db [3];
    logic signed [DW-1:0] g_w  [3];

    // stage 0: start points, directions and start offset
    always_comb
    begin
        side_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            side_next[OAS + k*COORD_BITS +: COORD_BITS] = a_s[k];
            side_next[OBS + k*COORD_BITS +: COORD_BITS] = b_s[k];
            side_next[ODA + k*DW +: DW] = DW'(a_e[k]) - DW'(a_s[k]);
            side_next[ODB + k*DW +: DW] = DW'(b_e[k]) - DW'(b_s[k]);
            side_next[OW  + k*DW +: DW] = DW'(a_s[k]) - DW'(b_s[k]);
        end
    end

    // geometry travels alongside the arithmetic
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            side_reg[0] <= side_next;
        end
        for (int k = 1; k < 8; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign side = side_reg[7];

    for (genvar k = 0; k < 3; k++)
    begin : g_unpack
        assign g_da[k] = signed'(side_reg[0][ODA + k*DW +: DW]);
        assign g_db[k] = signed'(side_reg[0][ODB + k*DW +: DW]);
        assign g_w[k]  = signed'(side_reg[0][OW  + k*DW +: DW]);
    end

    // stage 1: per-axis products
    logic signed [PW-1:0] paa_reg [3];
    logic signed [PW-1:0] pab_reg [3];
    logic signed [PW-1:0] pbb_reg [3];
    logic signed [PW-1:0] pad_reg [3];
    logic signed [PW-1:0] pbd_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                paa_reg[k] <= g_da[k] * g_da[k];
                pab_reg[k] <= g_da[k] * g_db[k];
                pbb_reg[k] <= g_db[k] * g_db[k];
                pad_reg[k] <= g_da[k] * g_w[k];
                pbd_reg[k] <= g_db[k] * g_w[k];
            end
        end
    end

    // stage 2: dot products
    logic signed [SW-1:0] a2_reg, b2_reg, c2_reg, d2_reg, e2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            a2_reg <= SW'(paa_reg[0]) + SW'(paa_reg[1]) + SW'(paa_reg[2]);
            b2_reg <= SW'(pab_reg[0]) + SW'(pab_reg[1]) + SW'(pab_reg[2]);
            c2_reg <= SW'(pbb_reg[0]) + SW'(pbb_reg[1]) + SW'(pbb_reg[2]);
            d2_reg <= SW'(pad_reg[0]) + SW'(pad_reg[1]) + SW'(pad_reg[2]);
            e2_reg <= SW'(pbd_reg[0]) + SW'(pbd_reg[1]) + SW'(pbd_reg[2]);
        end
    end

    // stage 3: cross products of the dot terms
    logic signed [MW-1:0] mac_reg, mbb_reg, mbe_reg, mcd_reg, mae_reg, mbd_reg;
    logic signed [SW-1:0] a3_reg, b3_reg, c3_reg, d3_reg, e3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            mac_reg <= a2_reg * c2_reg;
            mbb_reg <= b2_reg * b2_reg;
            mbe_reg <= b2_reg * e2_reg;
            mcd_reg <= c2_reg * d2_reg;
            mae_reg <= a2_reg * e2_reg;
            mbd_reg <= b2_reg * d2_reg;
            a3_reg  <= a2_reg;
            b3_reg  <= b2_reg;
            c3_reg  <= c2_reg;
            d3_reg  <= d2_reg;
            e3_reg  <= e2_reg;
        end
    end

    // stage 4: determinant and raw numerators
    logic signed [XW-1:0] det4_reg, sn4_reg, tn4_reg;
    logic signed [SW-1:0] a4_reg, b4_reg, c4_reg, d4_reg, e4_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            det4_reg <= XW'(mac_reg) - XW'(mbb_reg);
            sn4_reg  <= XW'(mbe_reg) - XW'(mcd_reg);
            tn4_reg  <= XW'(mae_reg) - XW'(mbd_reg);
            a4_reg   <= a3_reg;
            b4_reg   <= b3_reg;
            c4_reg   <= c3_reg;
            d4_reg   <= d3_reg;
            e4_reg   <= e3_reg;
        end
    end

    // stage 5: parallel test and clamp of the first parameter
    logic                 par;
    logic signed [XW-1:0] sn5_next, sd5_next, tn5_next, td5_next;
    logic signed [XW-1:0] sn5_reg, sd5_reg, tn5_reg, td5_reg;
    logic signed [SW-1:0] a5_reg, b5_reg, d5_reg;

    always_comb
    begin
        par      = det4_reg <= signed'(XW'(thr));
        sn5_next = sn4_reg;
        sd5_next = det4_reg;
        tn5_next = tn4_reg;
        td5_next = det4_reg;
        if (par)
        begin
            sn5_next = '0;
            sd5_next = XW'(c4_reg);
            tn5_next = XW'(e4_reg);
            td5_next = XW'(c4_reg);
        end
        else if (sn4_reg[XW-1])
        begin
            sn5_next = '0;
            tn5_next = XW'(e4_reg);
            td5_next = XW'(c4_reg);
        end
        else if (sn4_reg > det4_reg)
        begin
            sn5_next = det4_reg;
            tn5_next = XW'(e4_reg) + XW'(b4_reg);
            td5_next = XW'(c4_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            sn5_reg <= sn5_next;
            sd5_reg <= sd5_next;
            tn5_reg <= tn5_next;
            td5_reg <= td5_next;
            a5_reg  <= a4_reg;
            b5_reg  <= b4_reg;
            d5_reg  <= d4_reg;
        end
    end

    // stage 6: clamp of the second parameter, pick the two divisions
    logic signed [XW-1:0] num6_next [2];
    logic signed [XW-1:0] den6_next [2];
    sscp_pkg::udiv_ctl_t  ctl6_next [2];
    logic signed [XW-1:0] num6_reg  [2];
    logic signed [XW-1:0] den6_reg  [2];
    sscp_pkg::udiv_ctl_t  ctl6_reg  [2];

    always_comb
    begin
        num6_next[sscp_pkg::LANE_A] = sn5_reg;
        den6_next[sscp_pkg::LANE_A] = sd5_reg;
        ctl6_next[sscp_pkg::LANE_A] = '0;
        num6_next[sscp_pkg::LANE_B] = tn5_reg;
        den6_next[sscp_pkg::LANE_B] = td5_reg;
        ctl6_next[sscp_pkg::LANE_B] = '0;
        if (tn5_reg[XW-1])
        begin
            ctl6_next[sscp_pkg::LANE_B] = '{fixed: 1'b1, one: 1'b0};
            num6_next[sscp_pkg::LANE_A] = -XW'(d5_reg);
            den6_next[sscp_pkg::LANE_A] = XW'(a5_reg);
        end
        else if (tn5_reg > td5_reg)
        begin
            ctl6_next[sscp_pkg::LANE_B] = '{fixed: 1'b1, one: 1'b1};
            num6_next[sscp_pkg::LANE_A] = XW'(b5_reg) - XW'(d5_reg);
            den6_next[sscp_pkg::LANE_A] = XW'(a5_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            num6_reg <= num6_next;
            den6_reg <= den6_next;
            ctl6_reg <= ctl6_next;
        end
    end

    // stage 7: quotients known without dividing (zero or full scale)
    sscp_pkg::udiv_ctl_t  ctl7_next [2];
    logic signed [XW-1:0] num7_reg  [2];
    logic signed [XW-1:0] den7_reg  [2];
    sscp_pkg::udiv_ctl_t  ctl7_reg  [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            ctl7_next[l] = ctl6_reg[l];
            if (!ctl6_reg[l].fixed)
            begin
                if (num6_reg[l][XW-1] || (num6_reg[l] == '0))
                begin
                    ctl7_next[l] = '{fixed: 1'b1, one: 1'b0};
                end
                else if (num6_reg[l] >= den6_reg[l])
                begin
                    ctl7_next[l] = '{fixed: 1'b1, one: 1'b1};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            num7_reg <= num6_reg;
            den7_reg <= den6_reg;
            ctl7_reg <= ctl7_next;
        end
    end

    assign num = num7_reg;
    assign den = den7_reg;
    assign ctl = ctl7_reg;

endmodule

`default_nettype wire

/* hdl/sscp_div.sv */
// ============================================================================
// sscp_div
// Two-lane pipelined restoring divider, one quotient bit per stage, then a
// round-to-nearest and full-scale cap stage.
// ============================================================================
`default_nettype none

module sscp_div #(
    parameter int COORD_BITS      = 16,
    parameter int PARAM_FRAC_BITS = 16,
    localparam int DW  = COORD_BITS + 1,
    localparam int XW  = 2 * (2 * DW + 2) + 3,
    localparam int SBW = 6 * COORD_BITS + 9 * DW,
    localparam int F   = PARAM_FRAC_BITS
) (
    input  logic                clk,
    input  logic [F:0]          en,
    input  logic signed [XW-1:0] num [2],
    input  logic signed [XW-1:0] den [2],
    input  sscp_pkg::udiv_ctl_t ctl [2],
    input  logic [SBW-1:0]      side_in,
    output logic [F:0]          u [2],
    output logic [SBW-1:0]      side_out
);

    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic [XW-1:0]       rem_reg  [2][F];
    logic [XW-1:0]       dvs_reg  [2][F];
    logic [F-1:0]        q_reg    [2][F];
    sscp_pkg::udiv_ctl_t ctl_reg  [2][F];
    logic [SBW-1:0]      side_reg [F];
    logic [F:0]          u_reg    [2];
    logic [SBW-1:0]      side_out_reg;

    // one quotient bit per stage
    for (genvar i = 0; i < F; i++)
    begin : g_step
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en[i])
                begin
                    side_reg[i] <= side_in;
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en[i])
                begin
                    side_reg[i] <= side_reg[i-1];
                end
            end
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [XW-1:0]       r_in;
            logic [XW-1:0]       d_in;
            logic [XW-1:0]       r_sh;
            logic [F-1:0]        q_in;
            sscp_pkg::udiv_ctl_t c_in;
            logic                ge;

            if (i == 0)
            begin : g_src
                assign r_in = num[l];
                assign d_in = den[l];
                assign q_in = '0;
                assign c_in = ctl[l];
            end
            else
            begin : g_src
                assign r_in = rem_reg[l][i-1];
                assign d_in = dvs_reg[l][i-1];
                assign q_in = q_reg[l][i-1];
                assign c_in = ctl_reg[l][i-1];
            end

            // trial subtract of the shifted remainder
            assign r_sh = {r_in[XW-2:0], 1'b0};
            assign ge   = r_sh >= d_in;

            always_ff @(posedge clk)
            begin
                if (en[i])
                begin
                    rem_reg[l][i] <= ge ? (r_sh - d_in) : r_sh;
                    dvs_reg[l][i] <= d_in;
                    q_reg[l][i]   <= {q_in[F-2:0], ge};
                    ctl_reg[l][i] <= c_in;
                end
            end
        end
    end

    // round half up from the final remainder, cap at one
    logic [F:0] u_next [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            logic [F:0] qq;
            logic       rnd;
            rnd = {rem_reg[l][F-1][XW-2:0], 1'b0} >= dvs_reg[l][F-1];
            qq  = {1'b0, q_reg[l][F-1]} + (F+1)'(rnd);
            if (ctl_reg[l][F-1].fixed)
            begin
                u_next[l] = ctl_reg[l][F-1].one ? ONE : '0;
            end
            else
            begin
                u_next[l] = (qq > ONE) ? ONE : qq;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[F])
        begin
            u_reg        <= u_next;
            side_out_reg <= side_reg[F-1];
        end
    end

    assign u        = u_reg;
    assign side_out = side_out_reg;

endmodule

`default_nettype wire

/* hdl/sscp_back.sv */
// ============================================================================
// sscp_back
// Four stages: parameter times direction, closest points and difference
// vector, squares, rounded squared distance into the output register.
// ============================================================================
`default_nettype none

module sscp_back #(
    parameter int COORD_BITS      = 16,
    parameter int PARAM_FRAC_BITS = 16,
    localparam int DW  = COORD_BITS + 1,
    localparam int SBW = 6 * COORD_BITS + 9 * DW,
    localparam int F   = PARAM_FRAC_BITS
) (
    input  logic             clk,
    input  logic [3:0]       en,
    input  logic [F:0]       u [2],
    input  logic [SBW-1:0]   side,
    output sscp_pkg::dist_t  sq_dist,
    output sscp_pkg::param_t u_a,
    output sscp_pkg::param_t u_b,
    output sscp_pkg::point_t pt_a [3],
    output sscp_pkg::point_t pt_b [3]
);

    localparam int OAS  = 0;
    localparam int OBS  = 3 * COORD_BITS;
    localparam int ODA  = 6 * COORD_BITS;
    localparam int ODB  = ODA + 3 * DW;
    localparam int OW   = ODB + 3 * DW;
    localparam int PAW  = F + 2 + DW;
    localparam int PTW  = PAW + 10;
    localparam int VW   = DW + F + 3;
    localparam int SQW  = 2 * VW + 2;
    localparam int S    = F - sscp_pkg::POINT_FRAC;
    localparam int RND  = (1 << S) >> 1;
    localparam int PMAX = (1 << (sscp_pkg::POINT_W - 1)) - 1;
    localparam int PMIN = -(1 << (sscp_pkg::POINT_W - 1));
    localparam logic [SQW-1:0] HALF = SQW'(1) << (2 * F - 1);
    localparam logic [SQW-2*F-1:0] DMAX = (SQW-2*F)'({sscp_pkg::DIST_W{1'b1}});

    logic signed [COORD_BITS-1:0] as_in [3];
    logic signed [COORD_BITS-1:0] bs_in [3];
    logic signed [DW-1:0]         da_in [3];
    logic signed [DW-1:0]         db_in [3];
    logic signed [DW-1:0]         w_in  [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_unpack
        assign as_in[k] = signed'(side[OAS + k*COORD_BITS +: COORD_BITS]);
        assign bs_in[k] = signed'(side[OBS + k*COORD_BITS +: COORD_BITS]);
        assign da_in[k] = signed'(side[ODA + k*DW +: DW]);
        assign db_in[k] = signed'(side[ODB + k*DW +: DW]);
        assign w_in[k]  = signed'(side[OW  + k*DW +: DW]);
    end

    // stage 0: parameter times direction
    logic signed [PAW-1:0]        pa0_reg [3];
    logic signed [PAW-1:0]        pb0_reg [3];
    logic signed [DW-1:0]         w0_reg  [3];
    logic signed [COORD_BITS-1:0] as0_reg [3];
    logic signed [COORD_BITS-1:0] bs0_reg [3];
    logic [F:0]                   u0_reg  [2];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                pa0_reg[k] <= signed'({1'b0, u[sscp_pkg::LANE_A]}) * da_in[k];
                pb0_reg[k] <= signed'({1'b0, u[sscp_pkg::LANE_B]}) * db_in[k];
                w0_reg[k]  <= w_in[k];
                as0_reg[k] <= as_in[k];
                bs0_reg[k] <= bs_in[k];
            end
            u0_reg <= u;
        end
    end

    // closest point: start in Q.8 plus rounded offset, saturated
    function automatic sscp_pkg::point_t mk_point(
        input logic signed [COORD_BITS-1:0] o,
        input logic signed [PAW-1:0]        t
    );
        logic signed [PTW-1:0] tr;
        logic signed [PTW-1:0] p;
        tr = (PTW'(t) + PTW'(RND)) >>> S;
        p  = (PTW'(o) <<< sscp_pkg::POINT_FRAC) + tr;
        if (p > PTW'(PMAX))
        begin
            mk_point = sscp_pkg::point_t'(PMAX);
        end
        else if (p < PTW'(PMIN))
        begin
            mk_point = sscp_pkg::point_t'(PMIN);
        end
        else
        begin
            mk_point = p[sscp_pkg::POINT_W-1:0];
        end
    endfunction

    // stage 1: difference vector and closest points
    logic signed [VW-1:0] v1_reg  [3];
    sscp_pkg::point_t     pta1_reg [3];
    sscp_pkg::point_t     ptb1_reg [3];
    logic [F:0]           u1_reg  [2];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                v1_reg[k]   <= (VW'(w0_reg[k]) <<< F) + VW'(pa0_reg[k]) - VW'(pb0_reg[k]);
                pta1_reg[k] <= mk_point(as0_reg[k], pa0_reg[k]);
                ptb1_reg[k] <= mk_point(bs0_reg[k], pb0_reg[k]);
            end
            u1_reg <= u0_reg;
        end
    end

    // stage 2: squares
    logic signed [2*VW-1:0] sq2_reg  [3];
    sscp_pkg::point_t       pta2_reg [3];
    sscp_pkg::point_t       ptb2_reg [3];
    logic [F:0]             u2_reg   [2];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq2_reg[k] <= v1_reg[k] * v1_reg[k];
            end
            pta2_reg <= pta1_reg;
            ptb2_reg <= ptb1_reg;
            u2_reg   <= u1_reg;
        end
    end

    // stage 3: sum, round to integer, saturate
    logic [SQW-1:0]       sum3;
    logic [SQW-2*F-1:0]   sh3;
    sscp_pkg::dist_t      dist_next;
    sscp_pkg::dist_t      dist_reg;
    sscp_pkg::param_t     ua_reg, ub_reg;
    sscp_pkg::point_t     pta_reg [3];
    sscp_pkg::point_t     ptb_reg [3];

    always_comb
    begin
        sum3 = SQW'(unsigned'(sq2_reg[0])) + SQW'(unsigned'(sq2_reg[1]))
             + SQW'(unsigned'(sq2_reg[2])) + HALF;
        sh3  = sum3[SQW-1:2*F];
        dist_next = (sh3 > DMAX) ? {sscp_pkg::DIST_W{1'b1}} : sh3[sscp_pkg::DIST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            dist_reg <= dist_next;
            ua_reg   <= sscp_pkg::PARAM_W'(u2_reg[sscp_pkg::LANE_A]);
            ub_reg   <= sscp_pkg::PARAM_W'(u2_reg[sscp_pkg::LANE_B]);
            pta_reg  <= pta2_reg;
            ptb_reg  <= ptb2_reg;
        end
    end

    assign sq_dist = dist_reg;
    assign u_a     = ua_reg;
    assign u_b     = ub_reg;
    assign pt_a    = pta_reg;
    assign pt_b    = ptb_reg;

endmodule

`default_nettype wire

/* hdl/sscp_checker.sv */
// ============================================================================
// sscp_checker
// Port-level checks on the closest-points block, bound to the top level.
// ============================================================================
`default_nettype none

module sscp_checker #(
    parameter int PARAM_FRAC_BITS = 16
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire sscp_pkg::dist_t  sq_dist,
    input wire sscp_pkg::param_t u_a,
    input wire sscp_pkg::param_t u_b
);

    localparam int CF = (PARAM_FRAC_BITS > 16) ? 16 : PARAM_FRAC_BITS;
    localparam logic [sscp_pkg::PARAM_W:0] ONE = (sscp_pkg::PARAM_W+1)'(1) << CF;

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(sq_dist) && $stable(u_a) && $stable(u_b))
        else $error("result payload changed while stalled");

    // input back-pressure only comes from a full, stalled pipeline
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // both parameters stay within [0, 1]
    a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (PARAM_FRAC_BITS > 16) ||
                      ({1'b0, u_a} <= ONE && {1'b0, u_b} <= ONE))
        else $error("segment parameter above one");

endmodule

bind segment_segment_closest_points sscp_checker #(
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
) u_sscp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (seg_in.ready),
    .out_valid (seg_out.valid),
    .out_ready (seg_out.ready),
    .sq_dist   (seg_out.sq_dist),
    .u_a       (seg_out.u_a),
    .u_b       (seg_out.u_b)
);

`default_nettype wire
